// ----- design/http_chunked_body_decoder_unit_macros.svh -----
// Assertion macros for the chunked body decoder.
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define HCBD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("hcbd: assertion failed");

// Expression must never be true outside reset.
`define HCBD_ASSERT_NEVER(lbl, clk, rstn, expr) \
  `HCBD_ASSERT(lbl, clk, rstn, !(expr))

`else

`define HCBD_ASSERT(lbl, clk, rstn, prop)
`define HCBD_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ----- design/hcbd_pkg.sv -----
// Shared types and constants of the chunked body decoder.
package hcbd_pkg;

  localparam int SIZE_WIDTH_DEF       = 64;
  localparam int LINE_COUNT_WIDTH_DEF = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_LW    = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY  = 2'd2;

  localparam logic [15:0] MAX_LINE_RST  = 16'd16384;
  localparam logic [31:0] MAX_CHUNK_RST = 32'd8192;
  localparam logic [31:0] MAX_BODY_RST  = 32'd16384;

  // Result kinds
  localparam logic [2:0] KIND_DATA  = 3'd0;
  localparam logic [2:0] KIND_DONE  = 3'd1;
  localparam logic [2:0] KIND_BAD   = 3'd2;
  localparam logic [2:0] KIND_BIG   = 3'd3;
  localparam logic [2:0] KIND_TRUNC = 3'd4;

  // Wire characters
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_TAB  = 8'h09;

  // Input action codes
  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_END  = 2'd1,
    OP_NEW  = 2'd2
  } op_e;

  // One classified input beat
  typedef struct packed {
    op_e        op;
    logic [7:0] wbyte;
    logic [3:0] hex;
    logic       is_hex;
    logic       is_cr;
    logic       is_lf;
    logic       is_sep;
  } item_t;

  typedef struct packed {
    logic                empty;
    logic                full;
    logic [QUEUE_LW-1:0] level;
  } q_status_t;

endpackage

// ----- design/http_chunked_body_decoder_unit.sv -----
// Top level of the chunked HTTP/1.1 body decoder.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o    | action_i, wire_byte_i
//  out     | output    | out_valid_o / out_stall_i  | kind_o, data_byte_o, chunk_last_o
//  cfg     | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
//  One input beat per clock cycle sustained while the queue is not full; a beat's result
//  reaches the result register through the queue (queue write, then the back end's update).
//  The clock-rate limit is the back end's framing update (line counter, size
//  shift-in and the body limit subtract-and-compare).
//  Reset is asynchronous, active low; no clearing pass, the block takes beats at once.
//  in_stall_o rises only once the four-entry queue is full, after out has held off a while.
module http_chunked_body_decoder_unit #(
  parameter int SIZE_WIDTH       = hcbd_pkg::SIZE_WIDTH_DEF,
  parameter int LINE_COUNT_WIDTH = hcbd_pkg::LINE_COUNT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input beats
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       action_i,
  input  logic [7:0]                       wire_byte_i,
  // result beats
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [2:0]                       kind_o,
  output logic [7:0]                       data_byte_o,
  output logic                             chunk_last_o,
  // limit registers
  input  logic                             cfg_we_i,
  input  logic [hcbd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hcbd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

`include "http_chunked_body_decoder_unit_macros.svh"

  hcbd_pkg::item_t     front_item;
  hcbd_pkg::item_t     q_item;
  hcbd_pkg::q_status_t q_status;
  logic                push;
  logic                pop;

  // Front end: takes the beat, drops unknown actions, pre-decodes the byte
  // (hex digit value, CR, LF, extension separator).
  hcbd_front u_front (
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .wire_byte_i (wire_byte_i),
    .q_status_i  (q_status),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .item_o      (front_item)
  );

  // Decoupling queue; lets the front keep accepting while a result waits on out.
  hcbd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (q_item),
    .status_o (q_status)
  );

  // Back end: size line, data, CRLF and trailer framing, limits, sticky errors.
  // It pops whenever its result register is free or being emptied this cycle.
  hcbd_back #(
    .SIZE_WIDTH       (SIZE_WIDTH),
    .LINE_COUNT_WIDTH (LINE_COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (q_item),
    .item_valid_i (~q_status.empty),
    .pop_o        (pop),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .kind_o       (kind_o),
    .data_byte_o  (data_byte_o),
    .chunk_last_o (chunk_last_o)
  );

  // Only data beats carry a byte or a last-of-chunk flag.
  `HCBD_ASSERT(a_ctrl_payload_zero, clk_i, rst_ni, out_valid_o && kind_o != hcbd_pkg::KIND_DATA |-> data_byte_o == 8'd0 && !chunk_last_o)

  // Queue occupancy stays within its depth.
  `HCBD_ASSERT(a_queue_level, clk_i, rst_ni, q_status.level <= hcbd_pkg::QUEUE_LW'(hcbd_pkg::QUEUE_DEPTH))

  // Input stall only appears after a beat was offered the cycle before.
  `HCBD_ASSERT(a_stall_rise, clk_i, rst_ni, $rose(in_stall_o) |-> $past(in_valid_i))

  // Back end never pops an empty queue.
  `HCBD_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop && q_status.empty)

endmodule

// ----- design/hcbd_front.sv -----
// Input side: accepts beats and classifies the wire byte.
module hcbd_front (
  input  logic                  in_valid_i,
  input  logic [1:0]            action_i,
  input  logic [7:0]            wire_byte_i,
  input  hcbd_pkg::q_status_t   q_status_i,
  output logic                  in_stall_o,
  output logic                  push_o,
  output hcbd_pkg::item_t       item_o
);

  logic keep;

  assign in_stall_o = q_status_i.full;

  // unknown action code has no effect at all, so it is dropped here
  always_comb begin
    keep = 1'b0;
    case (hcbd_pkg::op_e'(action_i))
      hcbd_pkg::OP_BYTE,
      hcbd_pkg::OP_END,
      hcbd_pkg::OP_NEW: keep = 1'b1;
      default:          keep = 1'b0;
    endcase
  end

  assign push_o = in_valid_i & ~q_status_i.full & keep;

  always_comb begin
    item_o        = '0;
    item_o.op     = hcbd_pkg::op_e'(action_i);
    item_o.wbyte  = wire_byte_i;
    item_o.is_cr  = (wire_byte_i == hcbd_pkg::CHAR_CR);
    item_o.is_lf  = (wire_byte_i == hcbd_pkg::CHAR_LF);
    item_o.is_sep = (wire_byte_i == hcbd_pkg::CHAR_SEMI) |
                    (wire_byte_i == hcbd_pkg::CHAR_SP) |
                    (wire_byte_i == hcbd_pkg::CHAR_TAB);
    if (wire_byte_i >= 8'h30 && wire_byte_i <= 8'h39) begin
      item_o.is_hex = 1'b1;
      item_o.hex    = wire_byte_i[3:0];
    end else if ((wire_byte_i >= 8'h61 && wire_byte_i <= 8'h66) ||
                 (wire_byte_i >= 8'h41 && wire_byte_i <= 8'h46)) begin
      item_o.is_hex = 1'b1;
      item_o.hex    = wire_byte_i[3:0] + 4'd9;
    end
  end

endmodule

// ----- design/hcbd_fifo.sv -----
// Short queue of classified beats between front and back.
module hcbd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hcbd_pkg::item_t     item_i,
  input  logic                pop_i,
  output hcbd_pkg::item_t     item_o,
  output hcbd_pkg::q_status_t status_o
);

  localparam int AW = hcbd_pkg::QUEUE_AW;
  localparam int LW = hcbd_pkg::QUEUE_LW;

  hcbd_pkg::item_t mem_q [hcbd_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [LW-1:0]   level_q, level_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(hcbd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(hcbd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      level_d = level_q + LW'(1);
    end else if (!push_i && pop_i) begin
      level_d = level_q - LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o         = mem_q[rd_ptr_q];
  assign status_o.empty = (level_q == '0);
  assign status_o.full  = (level_q == LW'(hcbd_pkg::QUEUE_DEPTH));
  assign status_o.level = level_q;

endmodule

// ----- design/hcbd_back.sv -----
// Framing state machine, limit registers and result register.
module hcbd_back #(
  parameter int SIZE_WIDTH       = hcbd_pkg::SIZE_WIDTH_DEF,
  parameter int LINE_COUNT_WIDTH = hcbd_pkg::LINE_COUNT_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hcbd_pkg::item_t                   item_i,
  input  logic                              item_valid_i,
  output logic                              pop_o,
  input  logic                              cfg_we_i,
  input  logic [hcbd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hcbd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [2:0]                        kind_o,
  output logic [7:0]                        data_byte_o,
  output logic                              chunk_last_o
);

  localparam int SW = SIZE_WIDTH;
  localparam int LCW = LINE_COUNT_WIDTH;
  localparam int MW = (LCW > 16) ? LCW : 16;
  localparam int XW = (SW > 32) ? SW : 32;
  localparam logic [MW-1:0] LINE_CAP = MW'({LCW{1'b1}});

  typedef enum logic [3:0] {
    PH_SIZE      = 4'd0,
    PH_SIZE_EXT  = 4'd1,
    PH_SIZE_BAD  = 4'd2,
    PH_DATA      = 4'd3,
    PH_CRLF1     = 4'd4,
    PH_CRLF2     = 4'd5,
    PH_CRLF2_BAD = 4'd6,
    PH_TRAILER   = 4'd7,
    PH_DONE      = 4'd8,
    PH_ERR_BAD   = 4'd9,
    PH_ERR_BIG   = 4'd10,
    PH_ERR_TRUNC = 4'd11
  } phase_e;

  // limit registers
  logic [15:0] max_line_q;
  logic [31:0] max_chunk_q;
  logic [31:0] max_body_q;

  phase_e          phase_q, phase_d;
  logic [SW-1:0]   chunk_q, chunk_d;
  logic            digits_q, digits_d;
  logic            cr_q, cr_d;
  logic [LCW-1:0]  len_q, len_d;
  logic [31:0]     total_q, total_d;

  logic            out_valid_q, out_valid_d;
  logic [2:0]      kind_q, kind_d;
  logic [7:0]      data_q, data_d;
  logic            last_q, last_d;

  // line byte counting
  logic [MW-1:0]   line_lim;
  logic            ln_end, ln_rel, ln_over, ln_content;
  logic            ok1, ok2;
  logic [LCW-1:0]  len1, len_next;
  phase_e          ph_tmp;

  logic            size_too_big;
  logic            body_too_big;
  logic [31:0]     body_left;

  function automatic logic [2:0] err_kind(phase_e ph);
    logic [2:0] k;
    case (ph)
      PH_ERR_BAD: k = hcbd_pkg::KIND_BAD;
      PH_ERR_BIG: k = hcbd_pkg::KIND_BIG;
      default:    k = hcbd_pkg::KIND_TRUNC;
    endcase
    return k;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q  <= hcbd_pkg::MAX_LINE_RST;
      max_chunk_q <= hcbd_pkg::MAX_CHUNK_RST;
      max_body_q  <= hcbd_pkg::MAX_BODY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hcbd_pkg::CFG_MAX_LINE:  max_line_q  <= cfg_data_i[15:0];
        hcbd_pkg::CFG_MAX_CHUNK: max_chunk_q <= cfg_data_i;
        hcbd_pkg::CFG_MAX_BODY:  max_body_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pop_o = item_valid_i & (~out_valid_q | ~out_stall_i);

  // A held CR that is not followed by LF counts as content, then the new byte counts too.
  assign line_lim   = (MW'(max_line_q) < LINE_CAP) ? MW'(max_line_q) : LINE_CAP;
  assign ln_end     = cr_q & item_i.is_lf;
  assign ln_rel     = cr_q & ~item_i.is_lf;
  assign ok1        = MW'(len_q) < line_lim;
  assign len1       = ln_rel ? len_q + LCW'(1) : len_q;
  assign ok2        = MW'(len1) < line_lim;
  assign len_next   = item_i.is_cr ? len1 : len1 + LCW'(1);
  assign ln_over    = ~ln_end & ((ln_rel & ~ok1) | (~item_i.is_cr & ~ok2));
  assign ln_content = ~ln_end & ~ln_over & ~item_i.is_cr;

  assign body_left    = max_body_q - total_q;
  assign size_too_big = XW'(chunk_q) > XW'(max_chunk_q);
  assign body_too_big = (total_q > max_body_q) | (XW'(chunk_q) > XW'(body_left));

  always_comb begin
    phase_d  = phase_q;
    chunk_d  = chunk_q;
    digits_d = digits_q;
    cr_d     = cr_q;
    len_d    = len_q;
    total_d  = total_q;
    ph_tmp   = phase_q;

    out_valid_d = out_valid_q & out_stall_i;
    kind_d      = kind_q;
    data_d      = data_q;
    last_d      = last_q;

    if (pop_o) begin
      out_valid_d = 1'b0;
      kind_d      = hcbd_pkg::KIND_DATA;
      data_d      = '0;
      last_d      = 1'b0;
      case (item_i.op)
        hcbd_pkg::OP_BYTE: begin
          case (phase_q)
            PH_SIZE, PH_SIZE_EXT, PH_SIZE_BAD: begin
              if (ln_over) begin
                phase_d     = PH_ERR_BIG;
                out_valid_d = 1'b1;
                kind_d      = hcbd_pkg::KIND_BIG;
              end else if (ln_end) begin
                cr_d = 1'b0;
                if (phase_q == PH_SIZE_BAD || !digits_q) begin
                  phase_d     = PH_ERR_BAD;
                  out_valid_d = 1'b1;
                  kind_d      = hcbd_pkg::KIND_BAD;
                end else if (chunk_q == '0) begin
                  phase_d  = PH_TRAILER;
                  digits_d = 1'b0;
                  len_d    = '0;
                end else if (size_too_big || body_too_big) begin
                  phase_d     = PH_ERR_BIG;
                  out_valid_d = 1'b1;
                  kind_d      = hcbd_pkg::KIND_BIG;
                end else begin
                  phase_d = PH_DATA;
                end
              end else begin
                cr_d  = item_i.is_cr;
                len_d = len_next;
                if (ln_rel && phase_q == PH_SIZE) begin
                  ph_tmp = PH_SIZE_BAD;
                end
                if (ln_content && ph_tmp == PH_SIZE) begin
                  if (item_i.is_hex) begin
                    if (chunk_q[SW-1 -: 4] != 4'd0) begin
                      ph_tmp = PH_SIZE_BAD;
                    end else begin
                      chunk_d  = {chunk_q[SW-5:0], item_i.hex};
                      digits_d = 1'b1;
                    end
                  end else if (digits_q && item_i.is_sep) begin
                    ph_tmp = PH_SIZE_EXT;
                  end else begin
                    ph_tmp = PH_SIZE_BAD;
                  end
                end
                phase_d = ph_tmp;
              end
            end
            PH_TRAILER: begin
              if (ln_over) begin
                phase_d     = PH_ERR_BIG;
                out_valid_d = 1'b1;
                kind_d      = hcbd_pkg::KIND_BIG;
              end else if (ln_end) begin
                cr_d = 1'b0;
                if (len_q == '0) begin
                  phase_d     = PH_DONE;
                  out_valid_d = 1'b1;
                  kind_d      = hcbd_pkg::KIND_DONE;
                end else begin
                  chunk_d  = '0;
                  digits_d = 1'b0;
                  len_d    = '0;
                end
              end else begin
                cr_d  = item_i.is_cr;
                len_d = len_next;
              end
            end
            PH_DATA: begin
              out_valid_d = 1'b1;
              data_d      = item_i.wbyte;
              total_d     = total_q + 32'd1;
              if (chunk_q != '0) begin
                chunk_d = chunk_q - SW'(1);
              end
              if (chunk_q[SW-1:1] == '0) begin
                last_d  = 1'b1;
                phase_d = PH_CRLF1;
              end
            end
            PH_CRLF1: begin
              phase_d = item_i.is_cr ? PH_CRLF2 : PH_CRLF2_BAD;
            end
            PH_CRLF2: begin
              if (!item_i.is_lf) begin
                phase_d     = PH_ERR_BAD;
                out_valid_d = 1'b1;
                kind_d      = hcbd_pkg::KIND_BAD;
              end else begin
                phase_d  = PH_SIZE;
                chunk_d  = '0;
                digits_d = 1'b0;
                cr_d     = 1'b0;
                len_d    = '0;
              end
            end
            PH_CRLF2_BAD: begin
              phase_d     = PH_ERR_BAD;
              out_valid_d = 1'b1;
              kind_d      = hcbd_pkg::KIND_BAD;
            end
            PH_ERR_BAD, PH_ERR_BIG, PH_ERR_TRUNC: begin
              out_valid_d = 1'b1;
              kind_d      = err_kind(phase_q);
            end
            default: ;
          endcase
        end
        hcbd_pkg::OP_END: begin
          if (phase_q == PH_ERR_BAD || phase_q == PH_ERR_BIG ||
              phase_q == PH_ERR_TRUNC) begin
            out_valid_d = 1'b1;
            kind_d      = err_kind(phase_q);
          end else if (phase_q != PH_DONE) begin
            phase_d     = PH_ERR_TRUNC;
            out_valid_d = 1'b1;
            kind_d      = hcbd_pkg::KIND_TRUNC;
          end
        end
        hcbd_pkg::OP_NEW: begin
          phase_d  = PH_SIZE;
          chunk_d  = '0;
          digits_d = 1'b0;
          cr_d     = 1'b0;
          len_d    = '0;
          total_d  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SIZE;
      chunk_q     <= '0;
      digits_q    <= 1'b0;
      cr_q        <= 1'b0;
      len_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= hcbd_pkg::KIND_DATA;
      data_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      chunk_q     <= chunk_d;
      digits_q    <= digits_d;
      cr_q        <= cr_d;
      len_q       <= len_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      data_q      <= data_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign data_byte_o  = data_q;
  assign chunk_last_o = last_q;

endmodule

// ----- tb/chunk_decode_checker.sv -----
// Watches the decoder's channels, predicts every result beat and compares it.
module chunk_decode_checker
  import hcbd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [1:0]            action_i,
  input  logic [7:0]            wire_byte_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [2:0]            kind_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  chunk_last_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           mismatches_o,
  output int unsigned           owed_o
);

  typedef enum logic [3:0] {
    ST_SIZE, ST_SIZE_EXT, ST_SIZE_BAD, ST_DATA, ST_CRLF1, ST_CRLF2, ST_CRLF2_BAD,
    ST_TRAILER, ST_DONE, ST_ERR_BAD, ST_ERR_BIG, ST_ERR_TRUNC
  } frame_st_e;

  typedef enum {LN_TEXT, LN_HOLD, LN_EOL, LN_LONG} line_ev_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } dec_result_t;

  // largest size that can still take one more hex digit
  localparam logic [63:0] SIZE_ROOM = {4'h0, {60{1'b1}}};

  frame_st_e   st;
  logic [63:0] remain;
  logic        digits;
  logic        cr_held;
  logic [15:0] line_len;
  logic [31:0] body_sum;
  logic [15:0] lim_line;
  logic [31:0] lim_chunk;
  logic [31:0] lim_body;

  dec_result_t decoded_beats[$];

  function automatic void new_line();
    remain   = '0;
    digits   = 1'b0;
    cr_held  = 1'b0;
    line_len = '0;
  endfunction

  function automatic bit take_char();
    if (line_len >= lim_line) return 1'b0;
    line_len++;
    return 1'b1;
  endfunction

  // a CR is held back until the next byte shows whether it ends the line
  function automatic line_ev_e feed_line(input logic [7:0] b, output bit rel);
    rel = 1'b0;
    if (cr_held && b == CHAR_LF) begin
      cr_held = 1'b0;
      return LN_EOL;
    end
    if (cr_held) begin
      cr_held = 1'b0;
      rel     = 1'b1;
      if (!take_char()) return LN_LONG;
    end
    if (b == CHAR_CR) begin
      cr_held = 1'b1;
      return LN_HOLD;
    end
    if (!take_char()) return LN_LONG;
    return LN_TEXT;
  endfunction

  function automatic logic [2:0] trip(input frame_st_e s);
    st = s;
    case (s)
      ST_ERR_BAD: return KIND_BAD;
      ST_ERR_BIG: return KIND_BIG;
      default:    return KIND_TRUNC;
    endcase
  endfunction

  function automatic bit on_wire(input logic [7:0] b, output dec_result_t res);
    line_ev_e ev;
    bit       rel;
    int       d;
    res = '{kind: KIND_DATA, data: 8'h00, last: 1'b0};
    case (st)
      ST_SIZE, ST_SIZE_EXT, ST_SIZE_BAD: begin
        ev = feed_line(b, rel);
        if (ev == LN_LONG) begin
          res.kind = trip(ST_ERR_BIG);
          return 1'b1;
        end
        if (ev == LN_EOL) begin
          if (st == ST_SIZE_BAD || !digits) begin
            res.kind = trip(ST_ERR_BAD);
            return 1'b1;
          end
          if (remain == 0) begin
            new_line();
            st = ST_TRAILER;
            return 1'b0;
          end
          if (remain > {32'h0, lim_chunk} || body_sum > lim_body ||
              remain > {32'h0, lim_body - body_sum}) begin
            res.kind = trip(ST_ERR_BIG);
            return 1'b1;
          end
          st = ST_DATA;
          return 1'b0;
        end
        if (rel && st == ST_SIZE) st = ST_SIZE_BAD;
        if (ev == LN_TEXT && st == ST_SIZE) begin
          d = -1;
          if (b >= "0" && b <= "9") d = b - "0";
          else if (b >= "a" && b <= "f") d = b - "a" + 10;
          else if (b >= "A" && b <= "F") d = b - "A" + 10;
          if (d >= 0) begin
            if (remain > SIZE_ROOM) st = ST_SIZE_BAD;
            else begin
              remain = {remain[59:0], d[3:0]};
              digits = 1'b1;
            end
          end else if (digits && (b == CHAR_SEMI || b == CHAR_SP || b == CHAR_TAB)) begin
            st = ST_SIZE_EXT;
          end else begin
            st = ST_SIZE_BAD;
          end
        end
        return 1'b0;
      end
      ST_TRAILER: begin
        ev = feed_line(b, rel);
        if (ev == LN_LONG) begin
          res.kind = trip(ST_ERR_BIG);
          return 1'b1;
        end
        if (ev == LN_EOL) begin
          if (line_len == 0) begin
            st       = ST_DONE;
            res.kind = KIND_DONE;
            return 1'b1;
          end
          new_line();
        end
        return 1'b0;
      end
      ST_DATA: begin
        res.data = b;
        body_sum++;
        if (remain != 0) remain--;
        if (remain == 0) begin
          res.last = 1'b1;
          st       = ST_CRLF1;
        end
        return 1'b1;
      end
      ST_CRLF1: begin
        st = (b == CHAR_CR) ? ST_CRLF2 : ST_CRLF2_BAD;
        return 1'b0;
      end
      ST_CRLF2: begin
        if (b != CHAR_LF) begin
          res.kind = trip(ST_ERR_BAD);
          return 1'b1;
        end
        new_line();
        st = ST_SIZE;
        return 1'b0;
      end
      ST_CRLF2_BAD: begin
        res.kind = trip(ST_ERR_BAD);
        return 1'b1;
      end
      ST_ERR_BAD, ST_ERR_BIG, ST_ERR_TRUNC: begin
        res.kind = trip(st);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit decode_beat(input logic [1:0] act, input logic [7:0] b,
                                     output dec_result_t res);
    res = '{kind: KIND_DATA, data: 8'h00, last: 1'b0};
    case (act)
      OP_BYTE: return on_wire(b, res);
      OP_END: begin
        if (st == ST_ERR_BAD || st == ST_ERR_BIG || st == ST_ERR_TRUNC) begin
          res.kind = trip(st);
          return 1'b1;
        end
        if (st != ST_DONE) begin
          res.kind = trip(ST_ERR_TRUNC);
          return 1'b1;
        end
        return 1'b0;
      end
      OP_NEW: begin
        st = ST_SIZE;
        new_line();
        body_sum = '0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dec_result_t res;
    dec_result_t want;
    if (!rst_ni) begin
      lim_line  = MAX_LINE_RST;
      lim_chunk = MAX_CHUNK_RST;
      lim_body  = MAX_BODY_RST;
      st        = ST_SIZE;
      new_line();
      body_sum  = '0;
      decoded_beats.delete();
      mismatches_o = 0;
      owed_o       = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_LINE:  lim_line  = cfg_data_i[15:0];
          CFG_MAX_CHUNK: lim_chunk = cfg_data_i;
          CFG_MAX_BODY:  lim_body  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (decode_beat(action_i, wire_byte_i, res)) decoded_beats.push_back(res);
      end
      if (out_valid_i && !out_stall_i) begin
        if (decoded_beats.size() == 0) begin
          $error("result beat with none awaited: kind %0d", kind_i);
          mismatches_o++;
        end else begin
          want = decoded_beats.pop_front();
          if (kind_i !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind_i);
            mismatches_o++;
          end
          if (data_byte_i !== want.data) begin
            $error("data_byte: expected %0h, got %0h", want.data, data_byte_i);
            mismatches_o++;
          end
          if (chunk_last_i !== want.last) begin
            $error("chunk_last: expected %0b, got %0b", want.last, chunk_last_i);
            mismatches_o++;
          end
        end
      end
      owed_o = decoded_beats.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// Stimulus and verdict for the chunked body decoder: chunked bodies, noise and limit phases.
module tb;
  import hcbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE      = 8;    // queue empties well inside this
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_BEATS = 250;
  localparam logic [1:0]  ACT_JUNK    = 2'd3; // undefined action, dropped by the block

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            action_i    = OP_BYTE;
  logic [7:0]            wire_byte_i = 8'h00;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [2:0]            kind_o;
  logic [7:0]            data_byte_o;
  logic                  chunk_last_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = CFG_MAX_LINE;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  int unsigned mismatches;
  int unsigned owed;
  int unsigned beats_sent = 0;
  int unsigned cycle_cnt  = 0;
  int          hold_left  = 0;
  bit          calm       = 1'b0; // no idling on either side while set
  bit          noisy      = 1'b0; // corrupt the current body now and then

  always #5 clk_i = ~clk_i;

  http_chunked_body_decoder_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .wire_byte_i  (wire_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .data_byte_o  (data_byte_o),
    .chunk_last_o (chunk_last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  chunk_decode_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .action_i     (action_i),
    .wire_byte_i  (wire_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_i       (kind_o),
    .data_byte_i  (data_byte_o),
    .chunk_last_i (chunk_last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .owed_o       (owed)
  );

  // Output back-pressure comes in bursts so the four-deep queue fills and
  // in_stall_o gets a workout; roughly one cycle in ten is stalled.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(99) < 2) begin
      hold_left = $urandom_range(1, 9);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: a hung handshake or a result that never turns up ends here.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL http_chunked_body_decoder_unit");
    $finish;
  end

  // One beat on the input channel. Stall is sampled on the falling edge, where
  // it is settled for the coming rising edge, so acceptance is race-free.
  task automatic put_beat(input logic [1:0] act, input logic [7:0] b);
    bit stalled;
    if (!calm && $urandom_range(99) < 5) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    wire_byte_i <= b;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    if (act != ACT_JUNK) beats_sent++;
  endtask

  // A wire byte, with the odd corruption when the body is marked noisy:
  // swapped byte, early end of input, junk action or a dropped byte.
  task automatic wire_out(input logic [7:0] b);
    int unsigned r;
    r = $urandom_range(999);
    if (noisy && r < 20) put_beat(OP_BYTE, 8'($urandom_range(0, 255)));
    else if (noisy && r < 33) begin
      if (r < 24) put_beat(OP_END, b);
      else if (r < 30) put_beat(ACT_JUNK, b);
      if (r < 30) put_beat(OP_BYTE, b);
    end else put_beat(OP_BYTE, b);
  endtask

  task automatic line_break();
    wire_out(CHAR_CR);
    wire_out(CHAR_LF);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) wire_out(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return "0" + nib;
    return ($urandom_range(1) ? "a" : "A") + nib - 4'd10;
  endfunction

  // extension / trailer text; now and then a bare CR, which counts as content
  function automatic logic [7:0] text_char();
    if ($urandom_range(11) == 0) return CHAR_CR;
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  task automatic send_size_hdr(input logic [63:0] sz);
    logic [63:0] v;
    int unsigned pick;
    int          nd;
    v    = sz;
    pick = $urandom_range(99);
    if (pick < 3) begin
      // seventeen digits: the last one no longer fits in the size register
      v = {$urandom, $urandom};
      v[63:60] = 4'($urandom_range(1, 15));
      wire_out(hex_char(4'($urandom_range(1, 15))));
    end else if (pick < 6) begin
      v = {$urandom, $urandom} >> $urandom_range(0, 40);
    end
    if (pick >= 6 && pick < 8) begin
      // no digits at all
    end else begin
      if (pick >= 8 && $urandom_range(99) < 15) wire_out("0");
      for (nd = 16; nd > 1 && v[4*nd-1 -: 4] == 4'h0; nd--) ;
      for (int i = nd; i > 0; i--) wire_out(hex_char(v[4*i-1 -: 4]));
    end
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(2))
        0:       wire_out(CHAR_SEMI);
        1:       wire_out(CHAR_SP);
        default: wire_out(CHAR_TAB);
      endcase
      repeat ($urandom_range(0, 4)) wire_out(text_char());
    end
    line_break();
  endtask

  // A whole body: a few short chunks, the last chunk, trailers and the blank line.
  // Some bodies are plain noise; a quarter carry random corruption.
  task automatic send_body();
    int unsigned sz;
    noisy = ($urandom_range(99) < 25);
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(3, 15)) begin
        put_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
      return;
    end
    put_beat(OP_NEW, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 3)) begin
      sz = ($urandom_range(15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      send_size_hdr(64'(sz));
      repeat (sz) wire_out(8'($urandom_range(0, 255)));
      line_break();
    end
    send_size_hdr(64'd0);
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 5)) wire_out(text_char());
      line_break();
    end
    line_break();
    case ($urandom_range(3))
      0:       put_beat(OP_END, 8'($urandom_range(0, 255)));
      1:       wire_out(8'($urandom_range(0, 255)));
      default: ;
    endcase
    noisy = 1'b0;
  endtask

  // Short directed run on the reset limits: a body with a tab extension and
  // extreme data bytes, traffic after done, a junk action, a bad digit with
  // its sticky repeats, and an early end of input.
  task automatic directed();
    send_text("2\tx");
    line_break();
    wire_out(8'h00);
    wire_out(8'hFF);
    line_break();
    send_text("0");
    line_break();
    line_break();
    wire_out("A");
    put_beat(OP_END, 8'h00);
    put_beat(ACT_JUNK, 8'h55);
    put_beat(OP_NEW, 8'hAA);
    send_text("g");
    line_break();
    wire_out("A");
    put_beat(OP_END, 8'h00);
    put_beat(OP_NEW, 8'h00);
    put_beat(OP_END, 8'hFF);
  endtask

  // Hold the sender until every awaited result is out, then let the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (owed != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [15:0] line, input logic [31:0] chunk,
                            input logic [31:0] body);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MAX_LINE;
    cfg_data_i <= {16'h0, line};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_CHUNK;
    cfg_data_i <= chunk;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_BODY;
    cfg_data_i <= body;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    int unsigned goal;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    drain();
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_limits(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: set_limits(16'd1, 32'd1, 32'd1);
        default: set_limits(16'($urandom_range(2, 12)), 32'($urandom_range(1, 12)),
                            32'($urandom_range(4, 40)));
      endcase
      calm = (ph == 2);
      goal = beats_sent + PHASE_BEATS;
      while (beats_sent < goal) send_body();
      calm = 1'b0;
      drain();
    end
    if (mismatches == 0) $display("PASS http_chunked_body_decoder_unit");
    else $display("FAIL http_chunked_body_decoder_unit");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/hcbd_pkg.sv
design/hcbd_front.sv
design/hcbd_fifo.sv
design/hcbd_back.sv
design/http_chunked_body_decoder_unit.sv
tb/chunk_decode_checker.sv
tb/tb.sv
